/* sv/lisp_lex_pkg.sv */
// ----------------------------------------------------------------------------
// lisp_lex_pkg
// Types, codes, character classes and result builders for the lisp token
// lexer.
// ----------------------------------------------------------------------------
package lisp_lex_pkg;

	// lexer modes
	typedef enum logic [3:0] {
		MODE_IDLE     = 4'd0,
		MODE_NUM      = 4'd1,
		MODE_STR      = 4'd2,
		MODE_STR_END  = 4'd3,
		MODE_SYM      = 4'd4,
		MODE_HASH     = 4'd5,
		MODE_LIT_T    = 4'd6,
		MODE_LIT_F    = 4'd7,
		MODE_CHAR     = 4'd8,
		MODE_CHAR_END = 4'd9,
		MODE_ERR      = 4'd10
	} mode_t;

	// event kinds
	localparam logic [1:0] EV_CONTENT = 2'd0;
	localparam logic [1:0] EV_TOKEN   = 2'd1;
	localparam logic [1:0] EV_ERROR   = 2'd2;

	// token kinds
	localparam logic [2:0] TOK_NUMBER = 3'd0;
	localparam logic [2:0] TOK_BOOL   = 3'd1;
	localparam logic [2:0] TOK_CHAR   = 3'd2;
	localparam logic [2:0] TOK_STRING = 3'd3;
	localparam logic [2:0] TOK_LPAREN = 3'd4;
	localparam logic [2:0] TOK_RPAREN = 3'd5;
	localparam logic [2:0] TOK_SYMBOL = 3'd6;
	localparam logic [2:0] TOK_QUOTE  = 3'd7;

	// error codes
	localparam logic [2:0] ERR_NO_DELIM     = 3'd0;
	localparam logic [2:0] ERR_BAD_DIGIT    = 3'd1;
	localparam logic [2:0] ERR_BAD_SYMBOL   = 3'd2;
	localparam logic [2:0] ERR_BAD_LITERAL  = 3'd3;
	localparam logic [2:0] ERR_DOT          = 3'd4;
	localparam logic [2:0] ERR_UNREADABLE   = 3'd5;
	localparam logic [2:0] ERR_RANGE        = 3'd6;
	localparam logic [2:0] ERR_UNTERMINATED = 3'd7;

	// characters the lexer tests against
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;

	// overflow bounds: floor((limit - d) / 10) is one of these two values
	localparam logic [63:0] ACC_BOUND_HI = 64'd922337203685477580;
	localparam logic [63:0] ACC_BOUND_LO = 64'd922337203685477579;
	localparam logic [3:0]  POS_REM      = 4'd7;
	localparam logic [3:0]  NEG_REM      = 4'd8;

	// one result transaction
	typedef struct packed {
		logic [1:0]  event_kind;
		logic [2:0]  token_kind;
		logic [7:0]  content_byte;
		logic [63:0] number_value;
		logic        bool_value;
		logic [2:0]  error_code;
		logic        last_of_run;
	} res_t;

	// character classes
	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'd32, [8'd9:8'd13]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"]};
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return (c == 8'd0) || is_space(c) || (c inside {"(", ")", "[", "]", "\"", ";", "#"});
	endfunction

	function automatic logic is_sym_start(input logic [7:0] c);
		return is_alpha(c) ||
			(c inside {"!", "$", "%", "&", "*", "/", ":", "<", "=", ">", "?", "^", "_", "~"});
	endfunction

	function automatic logic is_sym_char(input logic [7:0] c);
		return is_sym_start(c) || is_digit(c) || (c inside {"+", "-", ".", "@"});
	endfunction

	// result builders
	function automatic res_t make_fail(input logic [2:0] code);
		res_t r;
		r = '0;
		r.event_kind = EV_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic res_t make_token(input logic [2:0] kind);
		res_t r;
		r = '0;
		r.event_kind = EV_TOKEN;
		r.token_kind = kind;
		return r;
	endfunction

	function automatic res_t make_content(input logic [2:0] kind, input logic [7:0] c);
		res_t r;
		r = '0;
		r.event_kind   = EV_CONTENT;
		r.token_kind   = kind;
		r.content_byte = c;
		return r;
	endfunction

endpackage

/* sv/lisp_token_lexer_top.sv */
// ----------------------------------------------------------------------------
// lisp_token_lexer_top
// Streaming lexer for Scheme-like text, one byte or end mark per transaction.
// ----------------------------------------------------------------------------
// The lexer takes one byte (or an end-of-input mark) per input transaction and
// can accept a new one every clock cycle while the result queue has room. Each
// input byte is registered, then lexed combinationally against the lexer state;
// the zero, one or two results it causes go into a four-entry result queue that
// feeds the output channel. An input stalls only when that queue has fewer than
// two free entries. Bytes that raise two results (a delimiter that closes one
// token and opens another) can fill the queue and stall the input even with the
// output always ready. A byte's first result is offered once the byte has passed
// the input register and its results are written into the queue. After an error
// all bytes are dropped without results until the end mark.
module lisp_token_lexer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  char_code,
	input  logic        end_mark,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  event_kind,
	output logic [2:0]  token_kind,
	output logic [7:0]  content_byte,
	output logic [63:0] number_value,
	output logic        bool_value,
	output logic [2:0]  error_code,
	output logic        last_of_run
);

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       fire_s1;

	// lexer state
	lisp_lex_pkg::mode_t mode_q, mode_d;
	logic [63:0] accum_q, accum_d;
	logic        neg_q, neg_d;
	logic        hasd_q, hasd_d;
	logic [7:0]  pend_q, pend_d;

	// result queue
	lisp_lex_pkg::res_t fifo_q [4];
	logic [1:0] head_q, tail_q;
	logic [2:0] count_q;
	logic       pop;

	// results of the current byte
	lisp_lex_pkg::res_t r0, r1;
	logic [1:0] n_res;

	// token start and token close pieces
	lisp_lex_pkg::res_t  st_res, cl_res;
	logic                st_has, st_num, cl_has, cl_fail;
	lisp_lex_pkg::mode_t st_mode;
	logic [63:0]         st_acc;

	// digit step
	logic [3:0]  digit;
	logic [63:0] bound;
	logic        ovf;
	logic [63:0] acc_next;

	assign fire_s1    = valid_s1 && (count_q <= 3'd2);
	assign item_ready = !valid_s1 || fire_s1;
	assign pop        = result_valid && result_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			char_s1 <= char_code;
			end_s1  <= end_mark;
		end
	end

	// what starting a token at this byte does
	always_comb begin
		st_has  = 1'b0;
		st_res  = '0;
		st_mode = lisp_lex_pkg::MODE_IDLE;
		st_num  = 1'b0;
		st_acc  = '0;
		if (char_s1 == lisp_lex_pkg::CH_MINUS || lisp_lex_pkg::is_digit(char_s1)) begin
			st_mode = lisp_lex_pkg::MODE_NUM;
			st_num  = 1'b1;
			st_acc  = (char_s1 == lisp_lex_pkg::CH_MINUS) ? 64'd0 : {60'd0, char_s1[3:0]};
		end else if (char_s1 == lisp_lex_pkg::CH_HASH) begin
			st_mode = lisp_lex_pkg::MODE_HASH;
		end else if (char_s1 == lisp_lex_pkg::CH_DQUOTE) begin
			st_mode = lisp_lex_pkg::MODE_STR;
		end else if (char_s1 == lisp_lex_pkg::CH_LPAREN) begin
			st_has = 1'b1;
			st_res = lisp_lex_pkg::make_token(lisp_lex_pkg::TOK_LPAREN);
		end else if (char_s1 == lisp_lex_pkg::CH_RPAREN) begin
			st_has = 1'b1;
			st_res = lisp_lex_pkg::make_token(lisp_lex_pkg::TOK_RPAREN);
		end else if (char_s1 == 8'd0 || lisp_lex_pkg::is_space(char_s1)) begin
			st_has = 1'b0;
		end else if (lisp_lex_pkg::is_sym_start(char_s1)) begin
			st_mode = lisp_lex_pkg::MODE_SYM;
			st_has  = 1'b1;
			st_res  = lisp_lex_pkg::make_content(lisp_lex_pkg::TOK_SYMBOL, char_s1);
		end else if (char_s1 == lisp_lex_pkg::CH_DOT) begin
			st_mode = lisp_lex_pkg::MODE_ERR;
			st_has  = 1'b1;
			st_res  = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_DOT);
		end else if (char_s1 == lisp_lex_pkg::CH_QUOTE) begin
			st_has = 1'b1;
			st_res = lisp_lex_pkg::make_token(lisp_lex_pkg::TOK_QUOTE);
		end else begin
			st_mode = lisp_lex_pkg::MODE_ERR;
			st_has  = 1'b1;
			st_res  = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_UNREADABLE);
		end
	end

	// what closing the open token does
	always_comb begin
		cl_has  = 1'b1;
		cl_fail = 1'b0;
		cl_res  = '0;
		case (mode_q)
			lisp_lex_pkg::MODE_NUM: begin
				if (!hasd_q) begin
					cl_fail = 1'b1;
					cl_res  = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_RANGE);
				end else begin
					cl_res = lisp_lex_pkg::make_token(lisp_lex_pkg::TOK_NUMBER);
					cl_res.number_value = neg_q ? (64'd0 - accum_q) : accum_q;
				end
			end
			lisp_lex_pkg::MODE_STR_END: cl_res = lisp_lex_pkg::make_token(lisp_lex_pkg::TOK_STRING);
			lisp_lex_pkg::MODE_SYM:     cl_res = lisp_lex_pkg::make_token(lisp_lex_pkg::TOK_SYMBOL);
			lisp_lex_pkg::MODE_LIT_T: begin
				cl_res = lisp_lex_pkg::make_token(lisp_lex_pkg::TOK_BOOL);
				cl_res.bool_value = 1'b1;
			end
			lisp_lex_pkg::MODE_LIT_F:   cl_res = lisp_lex_pkg::make_token(lisp_lex_pkg::TOK_BOOL);
			lisp_lex_pkg::MODE_CHAR_END: begin
				cl_res = lisp_lex_pkg::make_token(lisp_lex_pkg::TOK_CHAR);
				cl_res.content_byte = pend_q;
			end
			lisp_lex_pkg::MODE_STR: begin
				cl_fail = 1'b1;
				cl_res  = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_UNTERMINATED);
			end
			lisp_lex_pkg::MODE_HASH, lisp_lex_pkg::MODE_CHAR: begin
				cl_fail = 1'b1;
				cl_res  = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_BAD_LITERAL);
			end
			default: cl_has = 1'b0;
		endcase
	end

	// digit accumulation with overflow check against the signed range
	always_comb begin
		digit = char_s1[3:0];
		if (neg_q) begin
			bound = (digit > lisp_lex_pkg::NEG_REM) ? lisp_lex_pkg::ACC_BOUND_LO
				: lisp_lex_pkg::ACC_BOUND_HI;
		end else begin
			bound = (digit > lisp_lex_pkg::POS_REM) ? lisp_lex_pkg::ACC_BOUND_LO
				: lisp_lex_pkg::ACC_BOUND_HI;
		end
		ovf      = accum_q > bound;
		acc_next = {accum_q[60:0], 3'b000} + {accum_q[62:0], 1'b0} + {60'd0, digit};
	end

	// next state and results for one byte
	always_comb begin
		mode_d  = mode_q;
		accum_d = accum_q;
		neg_d   = neg_q;
		hasd_d  = hasd_q;
		pend_d  = pend_q;
		r0      = '0;
		r1      = '0;
		n_res   = 2'd0;
		if (end_s1) begin
			if (mode_q != lisp_lex_pkg::MODE_ERR && cl_has) begin
				r0    = cl_res;
				n_res = 2'd1;
			end
			mode_d  = lisp_lex_pkg::MODE_IDLE;
			accum_d = '0;
			neg_d   = 1'b0;
			hasd_d  = 1'b0;
			pend_d  = '0;
		end else begin
			case (mode_q)
				lisp_lex_pkg::MODE_IDLE: begin
					r0     = st_res;
					n_res  = {1'b0, st_has};
					mode_d = st_mode;
					if (st_num) begin
						accum_d = st_acc;
						neg_d   = (char_s1 == lisp_lex_pkg::CH_MINUS);
						hasd_d  = (char_s1 != lisp_lex_pkg::CH_MINUS);
					end
				end
				lisp_lex_pkg::MODE_NUM: begin
					if (lisp_lex_pkg::is_digit(char_s1)) begin
						if (ovf) begin
							r0     = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_RANGE);
							n_res  = 2'd1;
							mode_d = lisp_lex_pkg::MODE_ERR;
						end else begin
							accum_d = acc_next;
							hasd_d  = 1'b1;
						end
					end else if (lisp_lex_pkg::is_delim(char_s1)) begin
						r0 = cl_res;
						if (cl_fail) begin
							n_res  = 2'd1;
							mode_d = lisp_lex_pkg::MODE_ERR;
						end else begin
							r1     = st_res;
							n_res  = st_has ? 2'd2 : 2'd1;
							mode_d = st_mode;
							if (st_num) begin
								accum_d = st_acc;
								neg_d   = (char_s1 == lisp_lex_pkg::CH_MINUS);
								hasd_d  = (char_s1 != lisp_lex_pkg::CH_MINUS);
							end
						end
					end else begin
						r0     = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_BAD_DIGIT);
						n_res  = 2'd1;
						mode_d = lisp_lex_pkg::MODE_ERR;
					end
				end
				lisp_lex_pkg::MODE_STR: begin
					if (char_s1 == lisp_lex_pkg::CH_DQUOTE) begin
						mode_d = lisp_lex_pkg::MODE_STR_END;
					end else begin
						r0    = lisp_lex_pkg::make_content(lisp_lex_pkg::TOK_STRING, char_s1);
						n_res = 2'd1;
					end
				end
				lisp_lex_pkg::MODE_SYM: begin
					if (lisp_lex_pkg::is_delim(char_s1)) begin
						r0     = cl_res;
						r1     = st_res;
						n_res  = st_has ? 2'd2 : 2'd1;
						mode_d = st_mode;
						if (st_num) begin
							accum_d = st_acc;
							neg_d   = (char_s1 == lisp_lex_pkg::CH_MINUS);
							hasd_d  = (char_s1 != lisp_lex_pkg::CH_MINUS);
						end
					end else if (lisp_lex_pkg::is_sym_char(char_s1)) begin
						r0    = lisp_lex_pkg::make_content(lisp_lex_pkg::TOK_SYMBOL, char_s1);
						n_res = 2'd1;
					end else begin
						r0     = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_BAD_SYMBOL);
						n_res  = 2'd1;
						mode_d = lisp_lex_pkg::MODE_ERR;
					end
				end
				lisp_lex_pkg::MODE_HASH: begin
					if (char_s1 == lisp_lex_pkg::CH_T) begin
						mode_d = lisp_lex_pkg::MODE_LIT_T;
					end else if (char_s1 == lisp_lex_pkg::CH_F) begin
						mode_d = lisp_lex_pkg::MODE_LIT_F;
					end else if (char_s1 == lisp_lex_pkg::CH_BSLASH) begin
						mode_d = lisp_lex_pkg::MODE_CHAR;
					end else begin
						r0     = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_BAD_LITERAL);
						n_res  = 2'd1;
						mode_d = lisp_lex_pkg::MODE_ERR;
					end
				end
				lisp_lex_pkg::MODE_CHAR: begin
					pend_d = char_s1;
					mode_d = lisp_lex_pkg::MODE_CHAR_END;
				end
				lisp_lex_pkg::MODE_STR_END, lisp_lex_pkg::MODE_LIT_T,
				lisp_lex_pkg::MODE_LIT_F, lisp_lex_pkg::MODE_CHAR_END: begin
					if (lisp_lex_pkg::is_delim(char_s1)) begin
						r0     = cl_res;
						r1     = st_res;
						n_res  = st_has ? 2'd2 : 2'd1;
						mode_d = st_mode;
						if (st_num) begin
							accum_d = st_acc;
							neg_d   = (char_s1 == lisp_lex_pkg::CH_MINUS);
							hasd_d  = (char_s1 != lisp_lex_pkg::CH_MINUS);
						end
					end else begin
						r0     = lisp_lex_pkg::make_fail(lisp_lex_pkg::ERR_NO_DELIM);
						n_res  = 2'd1;
						mode_d = lisp_lex_pkg::MODE_ERR;
					end
				end
				default: mode_d = lisp_lex_pkg::MODE_ERR;
			endcase
		end
		// flag the last result of this byte
		if (n_res == 2'd1) begin
			r0.last_of_run = 1'b1;
		end else if (n_res == 2'd2) begin
			r1.last_of_run = 1'b1;
		end
	end

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lisp_lex_pkg::MODE_IDLE;
			accum_q <= '0;
			neg_q   <= 1'b0;
			hasd_q  <= 1'b0;
			pend_q  <= '0;
		end else if (fire_s1) begin
			mode_q  <= mode_d;
			accum_q <= accum_d;
			neg_q   <= neg_d;
			hasd_q  <= hasd_d;
			pend_q  <= pend_d;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (fire_s1 && n_res != 2'd0) begin
			fifo_q[tail_q] <= r0;
			if (n_res == 2'd2) begin
				fifo_q[tail_q + 2'd1] <= r1;
			end
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 2'd1;
			end
			if (fire_s1) begin
				tail_q <= tail_q + n_res;
			end
			count_q <= count_q + (fire_s1 ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
		end
	end

	// output transaction
	assign result_valid = (count_q != 3'd0);
	assign event_kind   = fifo_q[head_q].event_kind;
	assign token_kind   = fifo_q[head_q].token_kind;
	assign content_byte = fifo_q[head_q].content_byte;
	assign number_value = fifo_q[head_q].number_value;
	assign bool_value   = fifo_q[head_q].bool_value;
	assign error_code   = fifo_q[head_q].error_code;
	assign last_of_run  = fifo_q[head_q].last_of_run;

endmodule
